FILE: design/ofp_pkg.sv
// Shared types and constants for the optical flow frame parser.
// Used by ofp_ctrl, ofp_byte_cell and optical_flow_frame_parser; no dependencies.
`timescale 1ns / 1ps

package ofp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned PAYLOAD_LEN = 10;
  localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN + 1);

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] LEN_BYTE   = 8'h0A;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h55;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_LEN);

  // Frame phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_DATA = 5'b00100,
    PH_SUM  = 5'b01000,
    PH_END  = 5'b10000
  } phase_t;

  // Controls from the frame sequencer to the datapath
  typedef struct packed {
    logic shift;  // move the payload chain by one byte
    logic emit;   // the item closes a valid frame
  } ofp_ctl_t;

endpackage

FILE: design/optical_flow_frame_parser.sv
// Top level of the optical flow frame parser: sequencer, payload byte chain, result register.
// Depends on ofp_pkg, ofp_ctrl and ofp_byte_cell.
`timescale 1ns / 1ps

// Takes one received byte per cycle and emits one result per valid frame
// (0xFE, 0x0A, ten payload bytes, checksum, 0x55). The result is presented in
// the cycle after the end byte is accepted and is
// held in a single output register until taken. in_stall is raised only when
// that register holds an untaken, stalled result and the byte offered is an
// end byte slot, so all other bytes keep flowing at one per cycle. Payload
// bytes travel through a ten-cell shift chain; the checksum is not checked.
module optical_flow_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic [7:0]         out_quality,
  output logic [7:0]         out_version
);

  localparam int unsigned NCELL = ofp_pkg::PAYLOAD_LEN;

  ofp_pkg::phase_t   phase;
  ofp_pkg::ofp_ctl_t ctl;
  logic              accept;
  logic              out_full_stalled;

  // chain[0] is the incoming byte; chain[k] is the output of cell k-1
  logic [ofp_pkg::BYTE_W-1:0] chain [NCELL+1];

  logic                       out_valid_r, out_valid_nxt;
  logic [ofp_pkg::WORD_W-1:0] vel_x_r, vel_y_r;
  logic [ofp_pkg::BYTE_W-1:0] quality_r, version_r;

  // Stall only the end byte while a result is waiting and stalled
  assign out_full_stalled = out_valid_r && out_stall;
  assign in_stall         = out_full_stalled && (phase == ofp_pkg::PH_END);
  assign accept           = in_valid && !in_stall;

  ofp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .phase   (phase),
    .ctl     (ctl)
  );

  // Payload chain: after ten shifts cell k holds payload byte 9-k
  assign chain[0] = in_rx_byte;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ofp_byte_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  // Result valid: set on emit, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ctl.emit)                  out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result: negate both flow words, pass quality and version
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      vel_x_r   <= ofp_pkg::WORD_W'(0) - {chain[NCELL-1], chain[NCELL]};
      vel_y_r   <= ofp_pkg::WORD_W'(0) - {chain[NCELL-3], chain[NCELL-2]};
      quality_r <= chain[2];
      version_r <= chain[1];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_vel_x   = $signed(vel_x_r);
  assign out_vel_y   = $signed(vel_y_r);
  assign out_quality = quality_r;
  assign out_version = version_r;

  // A result is only produced when the register is free or being emptied
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !out_full_stalled)
    else $error("result overwritten while stalled");

  // An emitted result shows up in the next cycle
  a_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid)
    else $error("emitted result not presented");

  // Chain never shifts outside the payload phase
  a_shift_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |-> (accept && phase == ofp_pkg::PH_DATA))
    else $error("payload chain shifted outside the payload phase");

endmodule

FILE: design/ofp_byte_cell.sv
// One byte cell of the payload chain: holds a byte and hands it on to the next cell.
// Depends on ofp_pkg.
`timescale 1ns / 1ps

module ofp_byte_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [ofp_pkg::BYTE_W-1:0] d_in,
  output logic [ofp_pkg::BYTE_W-1:0] d_out
);

  logic [ofp_pkg::BYTE_W-1:0] byte_r;
  logic [ofp_pkg::BYTE_W-1:0] byte_nxt;

  // Take the neighbor's byte on a shift, otherwise hold
  always_comb begin
    byte_nxt = shift ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign d_out = byte_r;

endmodule

FILE: design/ofp_ctrl.sv
// Frame sequencer: tracks the frame phase and the payload byte count.
// Depends on ofp_pkg.
`timescale 1ns / 1ps

module ofp_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [ofp_pkg::BYTE_W-1:0] rx_byte,
  output ofp_pkg::phase_t            phase,
  output ofp_pkg::ofp_ctl_t          ctl
);

  ofp_pkg::phase_t          phase_r, phase_nxt;
  logic [ofp_pkg::CNT_W-1:0] count_r, count_nxt;

  // Next phase and count for the accepted item
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    ctl       = '0;
    if (accept) begin
      unique case (phase_r)
        ofp_pkg::PH_LEN: begin
          if (rx_byte == ofp_pkg::LEN_BYTE) phase_nxt = ofp_pkg::PH_DATA;
        end
        ofp_pkg::PH_DATA: begin
          if (count_r < ofp_pkg::CNT_FULL) begin
            ctl.shift = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (count_nxt >= ofp_pkg::CNT_FULL) phase_nxt = ofp_pkg::PH_SUM;
        end
        ofp_pkg::PH_SUM: begin
          phase_nxt = ofp_pkg::PH_END;
        end
        ofp_pkg::PH_END: begin
          phase_nxt = ofp_pkg::PH_HUNT;
          count_nxt = '0;
          ctl.emit  = (rx_byte == ofp_pkg::END_BYTE);
        end
        default: begin
          phase_nxt = (rx_byte == ofp_pkg::START_BYTE) ? ofp_pkg::PH_LEN
                                                       : ofp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ofp_pkg::PH_HUNT;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  assign phase = phase_r;

  // Count stays within the payload length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ofp_pkg::CNT_FULL)
    else $error("payload count out of range");

  // No stored bytes while hunting or waiting for the length byte
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ofp_pkg::PH_HUNT || phase_r == ofp_pkg::PH_LEN) |-> count_r == '0)
    else $error("payload count not clear outside a frame");

  // A full payload is held when the end byte is due
  a_end_full: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ofp_pkg::PH_SUM || phase_r == ofp_pkg::PH_END) |-> count_r == ofp_pkg::CNT_FULL)
    else $error("frame closing without a full payload");

  // The last payload byte moves the frame on to the checksum
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == ofp_pkg::PH_DATA && count_r == ofp_pkg::CNT_FULL - 1'b1)
      |=> phase_r == ofp_pkg::PH_SUM)
    else $error("payload phase did not end after the last byte");

endmodule

FILE: tb/optical_flow_frame_parser_tb.sv
// Self-checking testbench for optical_flow_frame_parser: directed frames from a table,
// then random frame streams under several idle and stall mixes.
// Depends on ofp_pkg and the optical_flow_frame_parser RTL.
`timescale 1ns / 1ps

module optical_flow_frame_parser_tb;

  // One decoded flow result
  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0]         quality;
    logic [7:0]         version;
  } flow_t;

  // One directed row: the byte, and the result it closes when typed in by hand
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    flow_t      res;
  } stim_row_t;

  localparam flow_t NO_FLOW     = '0;
  localparam int    N_DIRECTED  = 30;
  localparam int    ITEMS_PHASE = 275;
  localparam int    TAIL_CYCLES = 16;
  localparam int    CYCLE_LIMIT = 400000;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // dropped while hunting, start, start again dropped while waiting for length
    '{8'h00, 1'b0, NO_FLOW},
    '{8'hFE, 1'b0, NO_FLOW},
    '{8'hFE, 1'b0, NO_FLOW},
    '{8'h0A, 1'b0, NO_FLOW},
    // payload: x raw 0x8000 negates to itself, y raw 0x8001 gives the top value
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h80, 1'b0, NO_FLOW},
    '{8'h01, 1'b0, NO_FLOW},
    '{8'h80, 1'b0, NO_FLOW},
    '{8'h55, 1'b0, NO_FLOW},
    '{8'hFE, 1'b0, NO_FLOW},
    '{8'h0A, 1'b0, NO_FLOW},
    '{8'h7F, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    // checksum, then good end byte
    '{8'hFE, 1'b0, NO_FLOW},
    '{8'h55, 1'b1, '{16'sh8000, 16'sh7FFF, 8'hFF, 8'h00}},
    // second frame with a bad end byte: dropped
    '{8'hFE, 1'b0, NO_FLOW},
    '{8'h0A, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'hFF, 1'b0, NO_FLOW},
    '{8'h00, 1'b0, NO_FLOW},
    '{8'h54, 1'b0, NO_FLOW}
  };

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte  = 8'h00;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [15:0] out_vel_x;
  logic signed [15:0] out_vel_y;
  logic [7:0]         out_quality;
  logic [7:0]         out_version;

  // Parser shadow state
  ofp_pkg::phase_t frame_phase;
  int              frame_count;
  logic [7:0]      frame_data [ofp_pkg::PAYLOAD_LEN];

  flow_t flow_q [$];
  int    mismatches     = 0;
  int    cycle_count    = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;

  optical_flow_frame_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_vel_x   (out_vel_x),
    .out_vel_y   (out_vel_y),
    .out_quality (out_quality),
    .out_version (out_version)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the frame parser by one byte; return 1 when a valid frame closes
  function automatic bit parse_byte(input logic [7:0] b, output flow_t r);
    r = NO_FLOW;
    case (frame_phase)
      ofp_pkg::PH_LEN: begin
        if (b == ofp_pkg::LEN_BYTE) frame_phase = ofp_pkg::PH_DATA;
      end
      ofp_pkg::PH_DATA: begin
        if (frame_count < ofp_pkg::PAYLOAD_LEN) begin
          frame_data[frame_count] = b;
          frame_count++;
        end
        if (frame_count >= ofp_pkg::PAYLOAD_LEN) frame_phase = ofp_pkg::PH_SUM;
      end
      ofp_pkg::PH_SUM: begin
        frame_phase = ofp_pkg::PH_END;
      end
      ofp_pkg::PH_END: begin
        frame_phase = ofp_pkg::PH_HUNT;
        frame_count = 0;
        if (b == ofp_pkg::END_BYTE) begin
          r.vel_x   = -{frame_data[1], frame_data[0]};
          r.vel_y   = -{frame_data[3], frame_data[2]};
          r.quality = frame_data[8];
          r.version = frame_data[9];
          return 1'b1;
        end
      end
      default: begin
        if (b == ofp_pkg::START_BYTE) frame_phase = ofp_pkg::PH_LEN;
        else frame_phase = ofp_pkg::PH_HUNT;
      end
    endcase
    return 1'b0;
  endfunction

  // Bias random bytes toward the extremes and the framing codes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return ofp_pkg::START_BYTE;
      5: return ofp_pkg::LEN_BYTE;
      6: return ofp_pkg::END_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item, hold it until accepted, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed, input flow_t typed_res);
    flow_t r;
    bit    has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = parse_byte(b, r);
    if (typed) flow_q.push_back(typed_res);
    else if (has) flow_q.push_back(r);
  endtask

  // One frame: start, optional junk before the length byte, payload, checksum, end
  task automatic send_frame(input bit good_end, input int junk);
    logic [7:0] b;
    send_byte(ofp_pkg::START_BYTE, 1'b0, NO_FLOW);
    repeat (junk) begin
      b = pick_byte();
      if (b == ofp_pkg::LEN_BYTE) b = 8'h00;
      send_byte(b, 1'b0, NO_FLOW);
    end
    send_byte(ofp_pkg::LEN_BYTE, 1'b0, NO_FLOW);
    repeat (ofp_pkg::PAYLOAD_LEN + 1) send_byte(pick_byte(), 1'b0, NO_FLOW);
    b = good_end ? ofp_pkg::END_BYTE : pick_byte();
    if (!good_end && b == ofp_pkg::END_BYTE) b = ~ofp_pkg::END_BYTE;
    send_byte(b, 1'b0, NO_FLOW);
  endtask

  // Mostly good frames, some bad ends, junk before length, and line noise
  task automatic send_random(input int n_items);
    int sent;
    int kind;
    int junk;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0, NO_FLOW);
      end else begin
        junk = (kind < 22) ? $urandom_range(1, 3) : 0;
        send_frame(kind >= 30, junk);
        sent += ofp_pkg::PAYLOAD_LEN + 4 + junk;
      end
    end
  endtask

  // Hold the sender until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (flow_q.size() != 0);
  endtask

  // Take results, compare with the oldest expectation, and stall at random
  always @(posedge clk) begin : result_check
    flow_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (flow_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d q=%0h v=%0h", $time,
                 out_vel_x, out_vel_y, out_quality, out_version);
        mismatches++;
      end else begin
        want = flow_q.pop_front();
        if (out_vel_x !== want.vel_x) begin
          $display("%0t: vel_x expected %0d got %0d", $time, want.vel_x, out_vel_x);
          mismatches++;
        end
        if (out_vel_y !== want.vel_y) begin
          $display("%0t: vel_y expected %0d got %0d", $time, want.vel_y, out_vel_y);
          mismatches++;
        end
        if (out_quality !== want.quality) begin
          $display("%0t: quality expected %0h got %0h", $time, want.quality, out_quality);
          mismatches++;
        end
        if (out_version !== want.version) begin
          $display("%0t: version expected %0h got %0h", $time, want.version, out_version);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("optical_flow_frame_parser_tb failed");
      $finish;
    end
  end

  initial begin
    frame_phase = ofp_pkg::PH_HUNT;
    frame_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].res);
    end
    send_random(ITEMS_PHASE);
    drain();

    // Sender mostly idle
    send_idle_pct = 88;
    send_random(ITEMS_PHASE);
    drain();

    // Receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    send_random(ITEMS_PHASE);
    drain();

    // Both sides idle now and then
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    send_random(ITEMS_PHASE);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("optical_flow_frame_parser_tb passed");
    end else begin
      $display("optical_flow_frame_parser_tb failed");
    end
    $finish;
  end

endmodule
